/* rtl/huffman_code_builder_defines.svh */
// Assertion macros used by the block's top-level RTL.
`ifndef HUFFMAN_CODE_BUILDER_DEFINES_SVH
`define HUFFMAN_CODE_BUILDER_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is low.
`define HCB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hcb assertion failed");
// Next-cycle implication, disabled while reset is low.
`define HCB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hcb assertion failed");
`else
`define HCB_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define HCB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/hcb_pkg.sv */
package hcb_pkg;

    // parameter defaults
    localparam int SYMBOLS_DEF         = 256;
    localparam int COUNT_BITS_DEF      = 32;
    localparam int MAX_CODE_LENGTH_DEF = 63;

    // fixed field widths
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 6;
    localparam int CODE_W = 63;

    // datapath operations
    typedef logic [4:0] t_op;
    localparam t_op OP_NONE       = 5'd0;
    localparam t_op OP_INIT       = 5'd1;
    localparam t_op OP_SREAD      = 5'd2;
    localparam t_op OP_SLOAD      = 5'd3;
    localparam t_op OP_SNEXT      = 5'd4;
    localparam t_op OP_QREAD      = 5'd5;
    localparam t_op OP_SHIFT      = 5'd6;
    localparam t_op OP_PLACE      = 5'd7;
    localparam t_op OP_RDA        = 5'd8;
    localparam t_op OP_RDB        = 5'd9;
    localparam t_op OP_MERGE      = 5'd10;
    localparam t_op OP_ROOT       = 5'd11;
    localparam t_op OP_POP        = 5'd12;
    localparam t_op OP_LOAD       = 5'd13;
    localparam t_op OP_CREAD      = 5'd14;
    localparam t_op OP_DSTEP      = 5'd15;
    localparam t_op OP_EMIT_LEAF  = 5'd16;
    localparam t_op OP_EMIT_EMPTY = 5'd17;

    typedef struct packed {
        t_op  op;
        logic count;
    } t_cmd;

    typedef struct packed {
        logic any;
        logic nz;
        logic s_last;
        logic i_zero;
        logic gt;
        logic len_gt1;
        logic inner;
        logic top_zero;
        logic out_free;
    } t_sts;

endpackage

/* rtl/hcb_in_if.sv */
interface hcb_in_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [hcb_pkg::BYTE_W-1:0] byte_value;

    modport source(output valid, kind, byte_value, input ready);
    modport sink(input valid, kind, byte_value, output ready);
endinterface

/* rtl/hcb_out_if.sv */
interface hcb_out_if;
    logic                       valid;
    logic                       ready;
    logic [hcb_pkg::BYTE_W-1:0] symbol;
    logic [hcb_pkg::LEN_W-1:0]  code_length;
    logic [hcb_pkg::CODE_W-1:0] code_bits;
    logic                       valid_res;
    logic                       last;

    modport source(output valid, symbol, code_length, code_bits, valid_res, last,
                   input ready);
    modport sink(input valid, symbol, code_length, code_bits, valid_res, last,
                 output ready);
endinterface

/* rtl/hcb_datapath.sv */
module hcb_datapath #(
    parameter int SYMBOLS         = hcb_pkg::SYMBOLS_DEF,
    parameter int COUNT_BITS      = hcb_pkg::COUNT_BITS_DEF,
    parameter int MAX_CODE_LENGTH = hcb_pkg::MAX_CODE_LENGTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  hcb_pkg::t_cmd              i_cmd,
    input  logic [hcb_pkg::BYTE_W-1:0] i_byte,
    output hcb_pkg::t_sts              o_sts,
    hcb_out_if.source                  o_out
);
    localparam int QB = $clog2(SYMBOLS);
    localparam int NB = $clog2(2 * SYMBOLS - 1);
    localparam int WB = COUNT_BITS + QB;
    localparam int EW = WB + NB;
    localparam int LW = hcb_pkg::LEN_W;
    localparam int CW = hcb_pkg::CODE_W;
    localparam int SW = NB + LW + CW;
    localparam int QD = 1 << QB;

    // memories
    logic [COUNT_BITS-1:0] r_hist  [SYMBOLS];
    logic [EW-1:0]         r_queue [QD];
    logic [2*NB-1:0]       r_child [SYMBOLS-1];
    logic [SW-1:0]         r_stack [SYMBOLS];
    logic [SYMBOLS-1:0]    r_hv;

    // histogram pipeline
    logic [COUNT_BITS-1:0] r_h_rd, r_fw_val;
    logic                  r_h_rdv, r_s1_valid, r_fw_valid, r_any;
    logic [QB-1:0]         r_s1_addr, r_fw_addr, r_s;

    // queue and tree build
    logic [QB:0]   r_len, r_i, r_top;
    logic [QB-1:0] r_head, r_made;
    logic [EW-1:0] r_new, r_a, r_q_rd;
    logic [2*NB-1:0] r_ch_rd;
    logic [SW-1:0]   r_st_rd;

    // walk cursor and output register
    logic [NB-1:0] r_cur_node;
    logic [LW-1:0] r_cur_depth;
    logic [CW-1:0] r_cur_code;
    logic          r_ov, r_o_valid_res, r_o_last;
    logic [hcb_pkg::BYTE_W-1:0] r_o_sym;
    logic [LW-1:0] r_o_len;
    logic [CW-1:0] r_o_code;

    hcb_pkg::t_op op;
    logic          byte_ok, cnt_go, can_deepen, out_free, emit_last;
    logic [QB-1:0] h_raddr, q_raddr, q_waddr, st_waddr, st_raddr, ch_idx;
    logic [QB:0]   top_dec;
    logic [COUNT_BITS-1:0] h_val, h_cur, h_next;
    logic [WB-1:0] sum_w;
    logic [NB-1:0] new_id, k_full, ch_l, ch_r;
    logic [LW-1:0] nd;
    logic [CW-1:0] lc, rc;

    assign op      = i_cmd.op;
    assign byte_ok = {1'b0, i_byte} < (hcb_pkg::BYTE_W + 1)'(SYMBOLS);
    assign cnt_go  = i_cmd.count && byte_ok;
    assign h_raddr = cnt_go ? i_byte[QB-1:0] : r_s;

    // read value with forwarding from the write issued in the previous cycle
    assign h_val  = r_h_rdv ? r_h_rd : '0;
    assign h_cur  = (r_fw_valid && (r_fw_addr == r_s1_addr)) ? r_fw_val : h_val;
    assign h_next = (h_cur == {COUNT_BITS{1'b1}}) ? h_cur : h_cur + COUNT_BITS'(1);

    // queue addressing
    always_comb begin
        unique case (op)
            hcb_pkg::OP_QREAD: q_raddr = r_head + r_i[QB-1:0] - QB'(1);
            hcb_pkg::OP_RDB:   q_raddr = r_head + QB'(1);
            default:           q_raddr = r_head;
        endcase
    end
    assign q_waddr = r_head + r_i[QB-1:0];
    assign sum_w   = r_a[EW-1:NB] + r_q_rd[EW-1:NB];
    assign new_id  = NB'(SYMBOLS) + NB'(r_made);

    // walk step
    assign top_dec    = r_top - (QB + 1)'(1);
    assign st_raddr   = top_dec[QB-1:0];
    assign st_waddr   = (op == hcb_pkg::OP_ROOT) ? '0 : r_top[QB-1:0];
    assign k_full     = r_cur_node - NB'(SYMBOLS);
    assign ch_idx     = k_full[QB-1:0];
    assign ch_l       = r_ch_rd[2*NB-1:NB];
    assign ch_r       = r_ch_rd[NB-1:0];
    assign can_deepen = r_cur_depth < LW'(MAX_CODE_LENGTH);
    assign nd = can_deepen ? r_cur_depth + LW'(1) : r_cur_depth;
    assign lc = can_deepen ? {r_cur_code[CW-2:0], 1'b0} : r_cur_code;
    assign rc = can_deepen ? {r_cur_code[CW-2:0], 1'b1} : r_cur_code;

    assign out_free  = !r_ov || o_out.ready;
    assign emit_last = (op == hcb_pkg::OP_EMIT_LEAF) && (r_top == '0);

    // memory ports
    always_ff @(posedge i_clk) begin
        if (cnt_go || op == hcb_pkg::OP_SREAD) begin
            r_h_rd  <= r_hist[h_raddr];
            r_h_rdv <= r_hv[h_raddr];
        end
        if (r_s1_valid) r_hist[r_s1_addr] <= h_next;
        if (op == hcb_pkg::OP_QREAD || op == hcb_pkg::OP_RDA || op == hcb_pkg::OP_RDB) begin
            r_q_rd <= r_queue[q_raddr];
        end
        if (op == hcb_pkg::OP_SHIFT) r_queue[q_waddr] <= r_q_rd;
        if (op == hcb_pkg::OP_PLACE) r_queue[q_waddr] <= r_new;
        if (op == hcb_pkg::OP_MERGE) r_child[r_made] <= {r_a[NB-1:0], r_q_rd[NB-1:0]};
        if (op == hcb_pkg::OP_CREAD) r_ch_rd <= r_child[ch_idx];
        if (op == hcb_pkg::OP_ROOT)  r_stack[st_waddr] <= {r_q_rd[NB-1:0], LW'(0), CW'(0)};
        if (op == hcb_pkg::OP_DSTEP) r_stack[st_waddr] <= {ch_r, nd, rc};
        if (op == hcb_pkg::OP_POP)   r_st_rd <= r_stack[st_raddr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv       <= '0;
            r_any      <= 1'b0;
            r_s1_valid <= 1'b0;
            r_fw_valid <= 1'b0;
            r_ov       <= 1'b0;
            r_s        <= '0;
            r_len      <= '0;
            r_i        <= '0;
            r_head     <= '0;
            r_made     <= '0;
            r_top      <= '0;
        end else begin
            r_s1_valid <= cnt_go;
            r_fw_valid <= r_s1_valid;
            if (cnt_go) r_any <= 1'b1;
            if (emit_last) begin
                r_hv  <= '0;
                r_any <= 1'b0;
            end else if (r_s1_valid) begin
                r_hv[r_s1_addr] <= 1'b1;
            end
            if (op == hcb_pkg::OP_EMIT_LEAF || op == hcb_pkg::OP_EMIT_EMPTY) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            unique case (op)
                hcb_pkg::OP_INIT: begin
                    r_s    <= '0;
                    r_len  <= '0;
                    r_head <= '0;
                    r_made <= '0;
                end
                hcb_pkg::OP_SLOAD: r_i <= r_len;
                hcb_pkg::OP_SNEXT: r_s <= r_s + QB'(1);
                hcb_pkg::OP_SHIFT: r_i <= r_i - (QB + 1)'(1);
                hcb_pkg::OP_PLACE: r_len <= r_len + (QB + 1)'(1);
                hcb_pkg::OP_MERGE: begin
                    r_made <= r_made + QB'(1);
                    r_head <= r_head + QB'(2);
                    r_len  <= r_len - (QB + 1)'(2);
                    r_i    <= r_len - (QB + 1)'(2);
                end
                hcb_pkg::OP_ROOT:  r_top <= (QB + 1)'(1);
                hcb_pkg::OP_POP:   r_top <= top_dec;
                hcb_pkg::OP_DSTEP: r_top <= r_top + (QB + 1)'(1);
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_s1_addr <= h_raddr;
        if (r_s1_valid) begin
            r_fw_addr <= r_s1_addr;
            r_fw_val  <= h_next;
        end
        unique case (op)
            hcb_pkg::OP_SLOAD: r_new <= {WB'(h_val), NB'(r_s)};
            hcb_pkg::OP_RDB:   r_a   <= r_q_rd;
            hcb_pkg::OP_MERGE: r_new <= {sum_w, new_id};
            hcb_pkg::OP_LOAD: begin
                r_cur_node  <= r_st_rd[SW-1:LW+CW];
                r_cur_depth <= r_st_rd[LW+CW-1:CW];
                r_cur_code  <= r_st_rd[CW-1:0];
            end
            hcb_pkg::OP_DSTEP: begin
                r_cur_node  <= ch_l;
                r_cur_depth <= nd;
                r_cur_code  <= lc;
            end
            hcb_pkg::OP_EMIT_LEAF: begin
                r_o_sym       <= hcb_pkg::BYTE_W'(r_cur_node);
                r_o_len       <= r_cur_depth;
                r_o_code      <= r_cur_code;
                r_o_valid_res <= 1'b1;
                r_o_last      <= (r_top == '0);
            end
            hcb_pkg::OP_EMIT_EMPTY: begin
                r_o_sym       <= '0;
                r_o_len       <= '0;
                r_o_code      <= '0;
                r_o_valid_res <= 1'b0;
                r_o_last      <= 1'b1;
            end
            default: ;
        endcase
    end

    // status back to the controller
    assign o_sts.any      = r_any;
    assign o_sts.nz       = (h_val != '0);
    assign o_sts.s_last   = (r_s == QB'(SYMBOLS - 1));
    assign o_sts.i_zero   = (r_i == '0);
    assign o_sts.gt       = (r_q_rd[EW-1:NB] > r_new[EW-1:NB]);
    assign o_sts.len_gt1  = (r_len > (QB + 1)'(1));
    assign o_sts.inner    = (r_cur_node >= NB'(SYMBOLS));
    assign o_sts.top_zero = (r_top == '0);
    assign o_sts.out_free = out_free;

    assign o_out.valid       = r_ov;
    assign o_out.symbol      = r_o_sym;
    assign o_out.code_length = r_o_len;
    assign o_out.code_bits   = r_o_code;
    assign o_out.valid_res   = r_o_valid_res;
    assign o_out.last        = r_o_last;
endmodule

/* rtl/hcb_controller.sv */
module hcb_controller (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_kind,
    output logic          o_in_ready,
    input  hcb_pkg::t_sts i_sts,
    output hcb_pkg::t_cmd o_cmd
);
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_BINIT = 5'd1;
    localparam logic [4:0] S_SREAD = 5'd2;
    localparam logic [4:0] S_SCHK  = 5'd3;
    localparam logic [4:0] S_SNEXT = 5'd4;
    localparam logic [4:0] S_ITEST = 5'd5;
    localparam logic [4:0] S_ICMP  = 5'd6;
    localparam logic [4:0] S_MTEST = 5'd7;
    localparam logic [4:0] S_MRDB  = 5'd8;
    localparam logic [4:0] S_MSUM  = 5'd9;
    localparam logic [4:0] S_ROOT  = 5'd10;
    localparam logic [4:0] S_POP   = 5'd11;
    localparam logic [4:0] S_LOAD  = 5'd12;
    localparam logic [4:0] S_DTEST = 5'd13;
    localparam logic [4:0] S_DSTEP = 5'd14;
    localparam logic [4:0] S_LEAF  = 5'd15;
    localparam logic [4:0] S_EMPTY = 5'd16;

    localparam logic RET_SCAN  = 1'b0;
    localparam logic RET_MERGE = 1'b1;

    logic [4:0] r_state, n_state;
    logic       r_walk, n_walk;
    logic       r_ret, n_ret;
    logic       accept;
    logic [4:0] ret_state;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign ret_state  = (r_ret == RET_MERGE) ? S_MTEST : S_SNEXT;

    // next state and command
    always_comb begin
        n_state     = r_state;
        n_walk      = r_walk;
        n_ret       = r_ret;
        o_cmd.op    = hcb_pkg::OP_NONE;
        o_cmd.count = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept && !i_in_kind) begin
                    o_cmd.count = !r_walk;
                end else if (accept) begin
                    if (r_walk) n_state = S_POP;
                    else if (i_sts.any) n_state = S_BINIT;
                    else n_state = S_EMPTY;
                end
            end
            S_BINIT: begin
                o_cmd.op = hcb_pkg::OP_INIT;
                n_state  = S_SREAD;
            end
            S_SREAD: begin
                o_cmd.op = hcb_pkg::OP_SREAD;
                n_state  = S_SCHK;
            end
            S_SCHK: begin
                if (i_sts.nz) begin
                    o_cmd.op = hcb_pkg::OP_SLOAD;
                    n_ret    = RET_SCAN;
                    n_state  = S_ITEST;
                end else begin
                    n_state = S_SNEXT;
                end
            end
            S_SNEXT: begin
                o_cmd.op = hcb_pkg::OP_SNEXT;
                n_state  = i_sts.s_last ? S_MTEST : S_SREAD;
            end
            // stable insert: shift heavier entries up from the tail
            S_ITEST: begin
                if (i_sts.i_zero) begin
                    o_cmd.op = hcb_pkg::OP_PLACE;
                    n_state  = ret_state;
                end else begin
                    o_cmd.op = hcb_pkg::OP_QREAD;
                    n_state  = S_ICMP;
                end
            end
            S_ICMP: begin
                if (i_sts.gt) begin
                    o_cmd.op = hcb_pkg::OP_SHIFT;
                    n_state  = S_ITEST;
                end else begin
                    o_cmd.op = hcb_pkg::OP_PLACE;
                    n_state  = ret_state;
                end
            end
            S_MTEST: begin
                o_cmd.op = hcb_pkg::OP_RDA;
                n_state  = i_sts.len_gt1 ? S_MRDB : S_ROOT;
            end
            S_MRDB: begin
                o_cmd.op = hcb_pkg::OP_RDB;
                n_state  = S_MSUM;
            end
            S_MSUM: begin
                o_cmd.op = hcb_pkg::OP_MERGE;
                n_ret    = RET_MERGE;
                n_state  = S_ITEST;
            end
            S_ROOT: begin
                o_cmd.op = hcb_pkg::OP_ROOT;
                n_walk   = 1'b1;
                n_state  = S_IDLE;
            end
            // preorder walk down the left spine
            S_POP: begin
                o_cmd.op = hcb_pkg::OP_POP;
                n_state  = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.op = hcb_pkg::OP_LOAD;
                n_state  = S_DTEST;
            end
            S_DTEST: begin
                if (i_sts.inner) begin
                    o_cmd.op = hcb_pkg::OP_CREAD;
                    n_state  = S_DSTEP;
                end else begin
                    n_state = S_LEAF;
                end
            end
            S_DSTEP: begin
                o_cmd.op = hcb_pkg::OP_DSTEP;
                n_state  = S_DTEST;
            end
            S_LEAF: begin
                if (i_sts.out_free) begin
                    o_cmd.op = hcb_pkg::OP_EMIT_LEAF;
                    if (i_sts.top_zero) n_walk = 1'b0;
                    n_state = S_IDLE;
                end
            end
            S_EMPTY: begin
                if (i_sts.out_free) begin
                    o_cmd.op = hcb_pkg::OP_EMIT_EMPTY;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_walk  <= 1'b0;
            r_ret   <= RET_SCAN;
        end else begin
            r_state <= n_state;
            r_walk  <= n_walk;
            r_ret   <= n_ret;
        end
    end
endmodule

/* rtl/huffman_code_builder.sv */
// Huffman code builder.
// Input channel i_in: kind 0 counts byte_value into a saturating histogram,
// kind 1 requests the next code table entry. Output channel o_out carries
// symbol, code_length, code_bits, valid_res and last.
// Byte counting takes one transaction per cycle while the controller is idle,
// through a two-stage read-modify-write on the histogram RAM, with forwarding
// between bytes. The first request builds the tree: one histogram scan plus a
// stable insertion sort in the queue RAM; it returns nothing.
// Each later request pops the walk stack and descends the left spine, then
// loads the output register.
// An empty histogram answers a request with valid_res 0 and last 1.
// After the entry marked last the histogram is cleared through its per-entry
// valid bits and counting starts again.
// Reset (synchronous, active low) empties the histogram the same way.
// A stalled receiver holds the output register; bytes accepted while a table
// is being read out are not counted, and a further request waits at the
// output until it drains.
`include "huffman_code_builder_defines.svh"

module huffman_code_builder #(
    parameter int SYMBOLS         = hcb_pkg::SYMBOLS_DEF,
    parameter int COUNT_BITS      = hcb_pkg::COUNT_BITS_DEF,
    parameter int MAX_CODE_LENGTH = hcb_pkg::MAX_CODE_LENGTH_DEF
) (
    input logic       i_clk,
    input logic       i_rst_n,
    hcb_in_if.sink    i_in,
    hcb_out_if.source o_out
);
    hcb_pkg::t_cmd w_cmd;
    hcb_pkg::t_sts w_sts;
    logic          w_ready;

    assign i_in.ready = w_ready;

    hcb_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_kind  (i_in.kind),
        .o_in_ready (w_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    hcb_datapath #(
        .SYMBOLS         (SYMBOLS),
        .COUNT_BITS      (COUNT_BITS),
        .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_byte  (i_in.byte_value),
        .o_sts   (w_sts),
        .o_out   (o_out)
    );

    // an empty-table answer is always the final entry
    `HCB_ASSERT_NOW(a_empty_last, i_clk, i_rst_n, o_out.valid && !o_out.valid_res, o_out.last)
    // an accepted request takes the controller out of idle, so input ready drops
    `HCB_ASSERT_NEXT(a_req_busy, i_clk, i_rst_n, i_in.valid && w_ready && i_in.kind, !w_ready)
    // results are loaded only into a free output register
    `HCB_ASSERT_NOW(a_emit_free, i_clk, i_rst_n,
        w_cmd.op == hcb_pkg::OP_EMIT_LEAF || w_cmd.op == hcb_pkg::OP_EMIT_EMPTY, w_sts.out_free)
endmodule
